// ===== sv/sdrm_pkg.sv =====
`timescale 1ns / 1ps

package sdrm_pkg;

	// Command codes carried on the input tuser.
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_INIT  = 2'd3
	} cmd_t;

	// Kind of frame on the wire, one-hot.
	typedef enum logic [2:0] {
		KIND_IDLE  = 3'b001,
		KIND_WRITE = 3'b010,
		KIND_READ  = 3'b100
	} kind_t;

	localparam logic [7:0] READ_FLAG      = 8'h80;
	localparam logic [15:0] POWER_DOWN    = 16'h0010;
	localparam logic [3:0] LAST_INIT_STEP = 4'd9;
	localparam logic [3:0] CS_NONE        = 4'hF;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic [2:0] chip;
		logic       normal_mode;
		logic       sdo;
	} item_t;

	typedef struct packed {
		logic       rejected;
		logic       read_done;
		logic [7:0] read_data;
		logic       busy_res;
		logic       sdio;
		logic       sclk;
		logic [3:0] cs_n;
	} result_t;

	// Normal set-up sequence, {address, data} per step; steps past the end hold the last frame.
	function automatic logic [15:0] setup_frame(input logic [3:0] step);
		logic [15:0] f;
		case (step)
			4'd0: f = 16'h0000;
			4'd1: f = 16'h0288;
			4'd2: f = 16'h01C0;
			4'd3: f = 16'h0817;
			4'd4: f = 16'h09D2;
			4'd5: f = 16'h0A0F;
			4'd6: f = 16'h0BB5;
			4'd7: f = 16'h0C03;
			4'd8: f = 16'h0FB5;
			default: f = 16'h1003;
		endcase
		return f;
	endfunction

endpackage

// ===== sv/sdrm_engine.sv =====
`timescale 1ns / 1ps

module sdrm_engine #(
	parameter int CHIP_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  sdrm_pkg::item_t   item,
	output sdrm_pkg::result_t res
);

	localparam int CsUsed = (CHIP_COUNT > 4) ? 4 : CHIP_COUNT;
	localparam logic [3:0] AllSel = 4'(~((1 << CsUsed) - 1));

	logic [15:0]     tx_q, tx_d;
	logic [5:0]      cnt_q, cnt_d;
	sdrm_pkg::kind_t kind_q, kind_d;
	logic [7:0]      rx_q, rx_d;
	logic [3:0]      sel_q, sel_d;
	logic [3:0]      step_q, step_d;
	logic            act_q, act_d;
	logic            norm_q, norm_d;

	always_comb begin
		tx_d   = tx_q;
		cnt_d  = cnt_q;
		kind_d = kind_q;
		rx_d   = rx_q;
		sel_d  = sel_q;
		step_d = step_q;
		act_d  = act_q;
		norm_d = norm_q;
		res    = '0;
		res.cs_n = sdrm_pkg::CS_NONE;

		// Start handling; a start while a frame runs is dropped and flagged.
		if (kind_q != sdrm_pkg::KIND_IDLE) begin
			if (item.cmd != sdrm_pkg::CMD_TICK) begin
				res.rejected = 1'b1;
			end
		end else begin
			case (item.cmd)
				sdrm_pkg::CMD_WRITE: begin
					tx_d   = {item.reg_addr, item.wr_data};
					kind_d = sdrm_pkg::KIND_WRITE;
					sel_d  = AllSel;
					cnt_d  = '0;
				end
				sdrm_pkg::CMD_READ: begin
					tx_d   = {item.reg_addr + sdrm_pkg::READ_FLAG, 8'h00};
					kind_d = sdrm_pkg::KIND_READ;
					sel_d  = sdrm_pkg::CS_NONE;
					if (item.chip != 3'd0 && int'(item.chip) <= CsUsed) begin
						sel_d = ~(4'b0001 << 2'(item.chip - 3'd1));
					end
					cnt_d  = '0;
				end
				sdrm_pkg::CMD_INIT: begin
					act_d  = 1'b1;
					norm_d = item.normal_mode;
					step_d = '0;
					tx_d   = item.normal_mode ? sdrm_pkg::setup_frame(4'd0)
					                          : sdrm_pkg::POWER_DOWN;
					kind_d = sdrm_pkg::KIND_WRITE;
					sel_d  = AllSel;
					cnt_d  = '0;
				end
				default: ;
			endcase
		end

		// Wire activity for this tick.
		if (kind_d != sdrm_pkg::KIND_IDLE) begin
			res.busy_res = 1'b1;
			if (!cnt_d[5]) begin
				res.cs_n = sel_d;
				res.sclk = cnt_d[0];
				if (kind_d == sdrm_pkg::KIND_WRITE || !cnt_d[4]) begin
					res.sdio = tx_d[15];
					if (cnt_d[0]) begin
						tx_d = {tx_d[14:0], 1'b0};
					end
				end else if (cnt_d[0]) begin
					rx_d = {rx_d[6:0], item.sdo};
				end
				cnt_d = cnt_d + 6'd1;
			end else begin
				// Closing tick: selects high, read byte delivered, next init frame queued.
				if (kind_d == sdrm_pkg::KIND_READ) begin
					res.read_done = 1'b1;
					res.read_data = rx_d;
				end
				cnt_d = '0;
				if (act_d && norm_d && step_d < sdrm_pkg::LAST_INIT_STEP) begin
					step_d = step_d + 4'd1;
					tx_d   = sdrm_pkg::setup_frame(step_d);
					kind_d = sdrm_pkg::KIND_WRITE;
					sel_d  = AllSel;
				end else begin
					kind_d = sdrm_pkg::KIND_IDLE;
					act_d  = 1'b0;
					sel_d  = sdrm_pkg::CS_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q   <= '0;
			cnt_q  <= '0;
			kind_q <= sdrm_pkg::KIND_IDLE;
			rx_q   <= '0;
			sel_q  <= sdrm_pkg::CS_NONE;
			step_q <= '0;
			act_q  <= 1'b0;
			norm_q <= 1'b0;
		end else if (step_en) begin
			tx_q   <= tx_d;
			cnt_q  <= cnt_d;
			kind_q <= kind_d;
			rx_q   <= rx_d;
			sel_q  <= sel_d;
			step_q <= step_d;
			act_q  <= act_d;
			norm_q <= norm_d;
		end
	end

endmodule

// ===== sv/spi_dac_register_master.sv =====
`timescale 1ns / 1ps

// SPI register master for a bank of DAC chips, SPI mode 0, MSB first. Every input
// beat is one half period of SCLK and yields exactly one output beat giving the
// select, clock and data levels for that half period, plus status. A write command
// sends a 16-bit {address, data} frame with every select low; a read command selects
// one chip (1 to CHIP_COUNT, other values select none), sends the address with bit 7
// added, then samples sdo on the eight following high ticks and returns the byte with
// read_done on the closing tick. An init command sends one power-down frame, or ten
// set-up frames back to back in normal mode. Every frame takes 33 ticks: 32 bit ticks
// and one closing tick with SCLK low and the selects high. Start commands that arrive
// while a frame or init sequence runs are ignored and flagged with rejected.
// Throughput is one beat per clock cycle while the output side does not stall; a beat
// passes an input register and the frame state update into the output register,
// from which its result is presented on the output.

module spi_dac_register_master #(
	parameter int CHIP_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: reg_addr[7:0], wr_data[15:8], chip[18:16], normal_mode[19],
	// sdo[20], zero fill[23:21].
	input  logic [23:0] s_tdata,
	// Fields from bit 0: cmd[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: cs_n[3:0], sclk[4], sdio[5], busy_res[6], read_data[14:7],
	// read_done[15], rejected[16], zero fill[23:17].
	output logic [23:0] m_tdata
);

	sdrm_pkg::item_t   item_s1;
	logic              valid_s1;
	sdrm_pkg::result_t res;
	sdrm_pkg::result_t res_s2;
	logic              valid_s2;
	logic              load_s2;
	logic              load_s1;

	// The output register takes a new beat whenever it is empty or being drained;
	// the input register refills whenever its beat moves on.
	assign load_s2  = !valid_s2 || m_tready;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) begin
			item_s1.cmd         <= sdrm_pkg::cmd_t'(s_tuser);
			item_s1.reg_addr    <= s_tdata[7:0];
			item_s1.wr_data     <= s_tdata[15:8];
			item_s1.chip        <= s_tdata[18:16];
			item_s1.normal_mode <= s_tdata[19];
			item_s1.sdo         <= s_tdata[20];
		end
		if (load_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	// The frame state advances exactly once per beat, as it moves into the output register.
	sdrm_engine #(
		.CHIP_COUNT(CHIP_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(valid_s1 && load_s2),
		.item   (item_s1),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2};

endmodule

// ===== sim/tb_spi_dac_register_master.sv =====
`timescale 1ns / 1ps

// Scoreboard for the SPI wire levels. It carries its own copy of the frame state,
// works out the levels of every accepted tick beat and holds them until the
// matching output beat arrives.
class spi_wire_scoreboard;

	localparam int          N_CHIPS     = 4;
	localparam logic [5:0]  CLOSE_TICK  = 6'd32;
	localparam logic [5:0]  SEND_TICKS  = 6'd16;
	localparam logic [15:0] SETUP_WORDS [10] = '{
		16'h0000, 16'h0288, 16'h01C0, 16'h0817, 16'h09D2,
		16'h0A0F, 16'h0BB5, 16'h0C03, 16'h0FB5, 16'h1003
	};

	logic [15:0]       tx_word;
	logic [5:0]        tick_no;
	sdrm_pkg::kind_t   kind;
	logic [7:0]        rx_byte;
	logic [3:0]        sel_mask;
	logic [3:0]        init_step;
	logic              init_run;
	logic              init_norm;
	sdrm_pkg::result_t wire_levels_q[$];
	int                errors;

	function new();
		tx_word   = '0;
		tick_no   = '0;
		kind      = sdrm_pkg::KIND_IDLE;
		rx_byte   = '0;
		sel_mask  = sdrm_pkg::CS_NONE;
		init_step = '0;
		init_run  = 1'b0;
		init_norm = 1'b0;
		errors    = 0;
	endfunction

	function bit idle();
		return kind == sdrm_pkg::KIND_IDLE;
	endfunction

	function int pending();
		return wire_levels_q.size();
	endfunction

	// A write frame drives every select that exists on the bank low.
	function void load_write(logic [15:0] word);
		tx_word  = word;
		kind     = sdrm_pkg::KIND_WRITE;
		sel_mask = (N_CHIPS >= 4) ? 4'h0 : 4'(~((1 << N_CHIPS) - 1));
		tick_no  = '0;
	endfunction

	function void load_init();
		if (init_norm)
			load_write(SETUP_WORDS[(init_step > sdrm_pkg::LAST_INIT_STEP) ?
				sdrm_pkg::LAST_INIT_STEP : init_step]);
		else
			load_write(sdrm_pkg::POWER_DOWN);
	endfunction

	// One accepted input beat is one half SCLK period.
	function void take_tick(sdrm_pkg::cmd_t c, logic [7:0] addr, logic [7:0] data,
			logic [2:0] chip, logic normal, logic sdo);
		sdrm_pkg::result_t r;
		logic [7:0]        instr;
		logic [5:0]        t;
		bit                sending;
		r = '0;
		r.cs_n = sdrm_pkg::CS_NONE;
		if (kind != sdrm_pkg::KIND_IDLE) begin
			if (c != sdrm_pkg::CMD_TICK)
				r.rejected = 1'b1;
		end else begin
			case (c)
				sdrm_pkg::CMD_WRITE: begin
					load_write({addr, data});
				end
				sdrm_pkg::CMD_READ: begin
					instr    = addr + sdrm_pkg::READ_FLAG;
					tx_word  = {instr, 8'h00};
					kind     = sdrm_pkg::KIND_READ;
					sel_mask = sdrm_pkg::CS_NONE;
					if (chip >= 1 && chip <= N_CHIPS && chip <= 4)
						sel_mask[chip - 1] = 1'b0;
					tick_no  = '0;
				end
				sdrm_pkg::CMD_INIT: begin
					init_run  = 1'b1;
					init_norm = normal;
					init_step = '0;
					load_init();
				end
				default: ;
			endcase
		end

		if (kind != sdrm_pkg::KIND_IDLE) begin
			t = tick_no;
			r.busy_res = 1'b1;
			if (t < CLOSE_TICK) begin
				// A read sends its instruction byte in the first half, then only listens.
				sending = (kind == sdrm_pkg::KIND_WRITE) || (t < SEND_TICKS);
				r.cs_n  = sel_mask;
				r.sclk  = t[0];
				if (sending) begin
					r.sdio = tx_word[15];
					if (t[0])
						tx_word = tx_word << 1;
				end else if (t[0]) begin
					rx_byte = {rx_byte[6:0], sdo};
				end
				tick_no = t + 6'd1;
			end else begin
				if (kind == sdrm_pkg::KIND_READ) begin
					r.read_done = 1'b1;
					r.read_data = rx_byte;
				end
				tick_no = '0;
				if (init_run && init_norm && init_step < sdrm_pkg::LAST_INIT_STEP) begin
					init_step = init_step + 4'd1;
					load_init();
				end else begin
					kind     = sdrm_pkg::KIND_IDLE;
					init_run = 1'b0;
					sel_mask = sdrm_pkg::CS_NONE;
				end
			end
		end
		wire_levels_q.push_back(r);
	endfunction

	function void cmp(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	function void compare_levels(logic [23:0] beat);
		sdrm_pkg::result_t want;
		sdrm_pkg::result_t got;
		if (wire_levels_q.size() == 0) begin
			errors++;
			$display("%0t: output beat with nothing expected, expected none actual %0h",
				$time, beat);
			return;
		end
		want = wire_levels_q.pop_front();
		got  = sdrm_pkg::result_t'(beat[16:0]);
		cmp("cs_n", want.cs_n, got.cs_n);
		cmp("sclk", want.sclk, got.sclk);
		cmp("sdio", want.sdio, got.sdio);
		cmp("busy_res", want.busy_res, got.busy_res);
		cmp("read_data", want.read_data, got.read_data);
		cmp("read_done", want.read_done, got.read_done);
		cmp("rejected", want.rejected, got.rejected);
		cmp("fill", 0, beat[23:17]);
	endfunction
endclass

module tb_spi_dac_register_master;

	localparam int RANDOM_BEATS = 525;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// Fields from bit 0: reg_addr[7:0], wr_data[15:8], chip[18:16], normal_mode[19],
	// sdo[20], zero fill[23:21].
	logic [23:0] s_tdata;
	// Fields from bit 0: cmd[1:0].
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// Fields from bit 0: cs_n[3:0], sclk[4], sdio[5], busy_res[6], read_data[14:7],
	// read_done[15], rejected[16], zero fill[23:17].
	logic [23:0] m_tdata;

	spi_wire_scoreboard wire_sb = new();

	// Beats accepted so far; the random part runs until its share is reached.
	int beats_sent;
	// While a burst flag is set its side never idles, so back-to-back beats occur too.
	bit send_burst;
	bit take_burst;

	spi_dac_register_master #(
		.CHIP_COUNT(4)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sends one tick beat. The valid from the previous beat is only dropped when a gap
	// follows, so it never falls and rises within the same time step.
	task automatic send_beat(sdrm_pkg::cmd_t c, logic [7:0] addr, logic [7:0] data,
			logic [2:0] chip, logic normal, logic sdo);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {3'b000, sdo, normal, chip, data, addr};
		do @(posedge clk); while (!s_tready);
		// The beat went across at this edge; its levels are predicted right away.
		wire_sb.take_tick(c, addr, data, chip, normal, sdo);
		beats_sent++;
	endtask

	// Starts a frame or init sequence and ticks it through to idle. A start command
	// is slipped in at beat poke_at of the run, counting the start beat as zero, to
	// check that starts are refused while busy.
	task automatic run_frame(sdrm_pkg::cmd_t op, logic [7:0] addr, logic [7:0] data,
			logic [2:0] chip, logic normal, int poke_at);
		int             k;
		sdrm_pkg::cmd_t c;
		k = 0;
		send_beat(op, addr, data, chip, normal, 1'($urandom));
		while (!wire_sb.idle()) begin
			k++;
			c = (k == poke_at) ? sdrm_pkg::cmd_t'(2'($urandom_range(1, 3)))
			                   : sdrm_pkg::CMD_TICK;
			send_beat(c, 8'($urandom), 8'($urandom), 3'($urandom), 1'($urandom),
				1'($urandom));
		end
	endtask

	// Waits until every predicted output beat has been seen. Always advances at least
	// one edge so a valid dropped here cannot meet a raise in the same step.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (wire_sb.pending() != 0);
	endtask

	// Output side: random stalls, with stretches of none.
	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_burst = !take_burst;
			gap = take_burst ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			wire_sb.compare_levels(m_tdata);
		end
	end

	// Stimulus: a directed part over every command and corner, then random runs.
	initial begin
		int             goal;
		int             pick;
		sdrm_pkg::cmd_t c;
		logic           normal;
		logic [2:0]     chip;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= sdrm_pkg::CMD_TICK;
		beats_sent = 0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle ticks first: nothing selected and no clock.
		send_beat(sdrm_pkg::CMD_TICK, 8'hFF, 8'hFF, 3'd7, 1'b1, 1'b1);
		send_beat(sdrm_pkg::CMD_TICK, 8'h00, 8'h00, 3'd0, 1'b0, 1'b0);
		// Writes at the data extremes; a start on the closing tick and one just
		// after the start are both refused.
		run_frame(sdrm_pkg::CMD_WRITE, 8'h00, 8'h00, 3'd0, 1'b0, -1);
		run_frame(sdrm_pkg::CMD_WRITE, 8'hFF, 8'hFF, 3'd7, 1'b1, 32);
		run_frame(sdrm_pkg::CMD_WRITE, 8'hA5, 8'h5A, 3'd2, 1'b0, 1);
		// Reads to each chip, with the address wrapping past 0xFF once bit 7 is added.
		run_frame(sdrm_pkg::CMD_READ, 8'h00, 8'hFF, 3'd1, 1'b0, -1);
		run_frame(sdrm_pkg::CMD_READ, 8'h7F, 8'h00, 3'd2, 1'b1, 20);
		run_frame(sdrm_pkg::CMD_READ, 8'h80, 8'h00, 3'd3, 1'b0, 32);
		run_frame(sdrm_pkg::CMD_READ, 8'hFF, 8'h00, 3'd4, 1'b0, -1);
		// Chip numbers that select nothing still run a full read.
		run_frame(sdrm_pkg::CMD_READ, 8'h12, 8'h00, 3'd0, 1'b0, -1);
		run_frame(sdrm_pkg::CMD_READ, 8'h34, 8'h00, 3'd5, 1'b0, -1);
		run_frame(sdrm_pkg::CMD_READ, 8'h56, 8'h00, 3'd7, 1'b1, -1);
		// Power-down init, then the full set-up sequence with a start refused in the
		// closing tick between two of its frames.
		run_frame(sdrm_pkg::CMD_INIT, 8'h00, 8'h00, 3'd0, 1'b0, 10);
		run_frame(sdrm_pkg::CMD_INIT, 8'hFF, 8'hFF, 3'd7, 1'b1, 32);
		run_frame(sdrm_pkg::CMD_INIT, 8'h00, 8'h00, 3'd0, 1'b1, 164);

		// Hold off the input side until the output side has caught up completely.
		drain();

		goal = beats_sent + RANDOM_BEATS;
		while (beats_sent < goal) begin
			pick   = $urandom_range(0, 99);
			normal = 1'($urandom);
			chip   = 3'($urandom);
			if (wire_sb.idle()) begin
				if (pick < 12) begin
					c = sdrm_pkg::CMD_TICK;
				end else if (pick < 52) begin
					c = sdrm_pkg::CMD_WRITE;
				end else if (pick < 88) begin
					c = sdrm_pkg::CMD_READ;
					if ($urandom_range(0, 3) != 0)
						chip = 3'($urandom_range(1, 4));
				end else begin
					c = sdrm_pkg::CMD_INIT;
					normal = ($urandom_range(0, 3) == 0);
				end
			end else begin
				c = (pick < 6) ? sdrm_pkg::cmd_t'(2'($urandom_range(1, 3)))
				               : sdrm_pkg::CMD_TICK;
			end
			send_beat(c, 8'($urandom), 8'($urandom), chip, normal, 1'($urandom));
		end

		drain();
		repeat (16) @(posedge clk);
		if (wire_sb.errors == 0 && wire_sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#(20_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
